// ===== hdl/nrc_pkg.sv =====
// Shared types, constants and map helpers for the nibble rotor cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package nrc_pkg;

  localparam int unsigned NibbleW    = 4;
  localparam int unsigned MapW       = 64;
  localparam int unsigned SymCount   = 16;
  localparam int unsigned RotorCount = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam logic [MapW-1:0] IdentityMap = 64'hFEDC_BA98_7654_3210;
  localparam logic [3:0] StepLast = 4'd8;   // step count runs 0..8

  typedef logic [NibbleW-1:0] nib_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRotorA    = 3'd0,
    CfgRotorB    = 3'd1,
    CfgRotorC    = 3'd2,
    CfgReflector = 3'd3,
    CfgPlugboard = 3'd4,
    CfgDecrypt   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [RotorCount-1:0][MapW-1:0] wiring;
    logic [MapW-1:0]                 reflector;
    logic [MapW-1:0]                 plugboard;
    logic                            decrypt;
  } nrc_cfg_t;

  typedef logic [RotorCount-1:0][NibbleW-1:0] offsets_t;

  function automatic nib_t map_nibble(input logic [MapW-1:0] map, input nib_t idx);
    return map[idx*NibbleW +: NibbleW];
  endfunction

  // Lowest input i whose rotated output equals s; s itself if none matches.
  function automatic nib_t rotor_inv(input logic [MapW-1:0] w, input nib_t off,
                                     input nib_t s);
    nib_t res;
    logic found;
    nib_t j;
    res   = s;
    found = 1'b0;
    for (int i = 0; i < SymCount; i++) begin
      j = NibbleW'(i) + off;
      if (!found && map_nibble(w, j) == s) begin
        res   = NibbleW'(i);
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/nibble_rotor_cipher_unit.sv =====
// Nibble rotor cipher, top level: item register, symbol sequencing, result register.
// Throughput: one symbol per cycle through the single symbol path unless output stalls;
// a new item is taken while the last symbol of the previous item passes the path.
// Registered results: encrypt low symbol, then encrypt high symbol or decrypt byte.
// Reset: identity maps, encrypt mode, rotor offsets and step count zero, no item held.
// Depends on nrc_pkg, nrc_cfg_regs, nrc_rotor_state, nrc_symbol_path.
`default_nettype none

module nibble_rotor_cipher_unit
  import nrc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [MapW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         plain_byte_i,
  input  wire logic [3:0]         cipher_low_i,
  input  wire logic [3:0]         cipher_high_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_value_o,
  output logic                    last_o
);

  nrc_cfg_t cfg;
  offsets_t offsets;
  nib_t     sym_in, sym_res;

  logic item_valid_q, phase_q;
  nib_t sym0_q, sym1_q, lo_q;
  logic out_valid_q, last_q;
  logic [7:0] out_value_q;

  logic accept, need_out, fire;

  nrc_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cfg_o(cfg)
  );

  nrc_rotor_state u_state (
    .clk_i, .rst_ni, .step_i(fire), .offsets_o(offsets)
  );

  nrc_symbol_path u_path (
    .cfg_i(cfg), .offsets_i(offsets), .sym_i(sym_in), .sym_o(sym_res)
  );

  // decrypt low symbol is held back until the high one completes the byte
  assign need_out   = !cfg.decrypt || phase_q;
  assign fire       = item_valid_q && (!out_valid_q || out_ready_i || !need_out);
  assign in_ready_o = !item_valid_q || (phase_q && fire);
  assign accept     = in_valid_i && in_ready_o;
  assign sym_in     = phase_q ? sym1_q : sym0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        item_valid_q <= 1'b1;
        phase_q      <= 1'b0;
      end else if (fire) begin
        phase_q <= !phase_q;
        if (phase_q) item_valid_q <= 1'b0;
      end
      if (fire && need_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym0_q <= cfg.decrypt ? cipher_low_i  : plain_byte_i[3:0];
      sym1_q <= cfg.decrypt ? cipher_high_i : plain_byte_i[7:4];
    end
    if (fire && !phase_q) lo_q <= sym_res;
    if (fire && need_out) begin
      out_value_q <= cfg.decrypt ? {sym_res, lo_q} : {4'd0, sym_res};
      last_q      <= phase_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hdl/nrc_cfg_regs.sv =====
// Configuration register file: rotor wirings, reflector, plugboard, mode.
// Depends on nrc_pkg.
`default_nettype none

module nrc_cfg_regs
  import nrc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [MapW-1:0]     cfg_data_i,
  output nrc_cfg_t                 cfg_o
);

  nrc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRotorA:    cfg_d.wiring[0] = cfg_data_i;
        CfgRotorB:    cfg_d.wiring[1] = cfg_data_i;
        CfgRotorC:    cfg_d.wiring[2] = cfg_data_i;
        CfgReflector: cfg_d.reflector = cfg_data_i;
        CfgPlugboard: cfg_d.plugboard = cfg_data_i;
        CfgDecrypt:   cfg_d.decrypt   = cfg_data_i[0];
        default:      ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wiring    <= {RotorCount{IdentityMap}};
      cfg_q.reflector <= IdentityMap;
      cfg_q.plugboard <= IdentityMap;
      cfg_q.decrypt   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/nrc_rotor_state.sv =====
// Rotor offsets and the mod-9 step counter, advanced once per symbol.
// Depends on nrc_pkg.
`default_nettype none

module nrc_rotor_state
  import nrc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  output offsets_t  offsets_o
);

  offsets_t   offsets_q, offsets_d;
  logic [3:0] count_q, count_d;
  logic       step_b, step_c;

  // rotor b every third symbol, rotor c every ninth
  assign step_b = (count_q == 4'd0) || (count_q == 4'd3) || (count_q == 4'd6);
  assign step_c = (count_q == 4'd0);

  always_comb begin
    offsets_d = offsets_q;
    count_d   = count_q;
    if (step_i) begin
      offsets_d[0] = offsets_q[0] + 4'd1;
      if (step_b) offsets_d[1] = offsets_q[1] + 4'd1;
      if (step_c) offsets_d[2] = offsets_q[2] + 4'd1;
      count_d = (count_q == StepLast) ? 4'd0 : count_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
      count_q   <= 4'd0;
    end else begin
      offsets_q <= offsets_d;
      count_q   <= count_d;
    end
  end

  assign offsets_o = offsets_q;

endmodule

`default_nettype wire

// ===== hdl/nrc_symbol_path.sv =====
// Combinational symbol path: plugboard, rotors forward, reflector,
// rotors inverse, plugboard. Depends on nrc_pkg.
`default_nettype none

module nrc_symbol_path
  import nrc_pkg::*;
(
  input  wire nrc_cfg_t  cfg_i,
  input  wire offsets_t  offsets_i,
  input  wire nib_t      sym_i,
  output nib_t           sym_o
);

  nib_t fwd [RotorCount+1];
  nib_t inv [RotorCount+1];

  always_comb begin
    fwd[0] = map_nibble(cfg_i.plugboard, sym_i);
    for (int k = 0; k < RotorCount; k++) begin
      fwd[k+1] = map_nibble(cfg_i.wiring[k], fwd[k] + offsets_i[k]);
    end
    inv[RotorCount] = map_nibble(cfg_i.reflector, fwd[RotorCount]);
    for (int k = RotorCount - 1; k >= 0; k--) begin
      inv[k] = rotor_inv(cfg_i.wiring[k], offsets_i[k], inv[k+1]);
    end
  end

  assign sym_o = map_nibble(cfg_i.plugboard, inv[0]);

endmodule

`default_nettype wire
